// ===== rtl/core/sssp_pkg.sv =====
// ----------------------------------------------------------------------------
// sssp_pkg: shared types and constants for the shortest path core.
// Holds the default node count, field widths and the controller command and
// status structures.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int NODES_DEFAULT = 32;
  localparam int ID_W          = 6;
  localparam int WEIGHT_W      = 16;
  localparam int DIST_W        = 22;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_write;   // write the requested weight into the matrix
    logic run_init;     // clear flags and queue, seed the source
    logic pop;          // pop the queue head into the current node
    logic edge_read;    // issue a matrix read for the scan column
    logic relax;        // evaluate the weight returned for the last read
    logic out_read;     // present the result for the output counter
  } sssp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic queue_empty;
    logic scan_last;    // the scan column is the final node
    logic out_last;     // the output counter is at the final node
  } sssp_status_t;

endpackage

// ===== rtl/core/sssp_datapath.sv =====
// ----------------------------------------------------------------------------
// sssp_datapath: weight matrix, distance tables, flags and work queue.
// Executes one edge relaxation a cycle during a column scan, under the controller's commands.
// ----------------------------------------------------------------------------
module sssp_datapath #(
  parameter int NODES = sssp_pkg::NODES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sssp_pkg::sssp_cmd_t           cmd,
  output sssp_pkg::sssp_status_t        status,
  input  logic [sssp_pkg::ID_W-1:0]     from_node,
  input  logic [sssp_pkg::ID_W-1:0]     to_node,
  input  logic [sssp_pkg::WEIGHT_W-1:0] weight,
  output logic                          strobe,
  output logic [sssp_pkg::ID_W-1:0]     node,
  output logic                          reachable,
  output logic [sssp_pkg::DIST_W-1:0]   distance,
  output logic [sssp_pkg::ID_W-1:0]     predecessor,
  output logic                          last
);

  localparam int IW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DEPTH = 1 << (2 * IW);
  localparam int CW    = $clog2(NODES + 1);

  // Weight matrix memory, cleared by a sweep after reset.
  logic [sssp_pkg::WEIGHT_W-1:0] matrix [DEPTH];
  logic [sssp_pkg::WEIGHT_W-1:0] rd_weight;
  logic [2*IW-1:0]               clr_addr;
  logic                          clearing;

  // Per-node tables and queue.
  logic [sssp_pkg::DIST_W-1:0] dist_tab [NODES];
  logic [IW-1:0]               prev_tab [NODES];
  logic [NODES-1:0]            reached;
  logic [NODES-1:0]            queued;
  logic [IW-1:0]               queue [NODES];
  logic [IW-1:0]               q_head;
  logic [CW-1:0]               q_count;

  // Scan state.
  logic [IW-1:0]               cur;
  logic [sssp_pkg::DIST_W-1:0] cur_dist;
  logic [IW-1:0]               col;
  logic [IW-1:0]               rd_col;
  logic [IW-1:0]               out_idx;

  logic [CW:0]                 tail_sum;
  logic [IW-1:0]               tail;
  logic [sssp_pkg::DIST_W-1:0] cand;
  logic                        improve;
  logic                        do_push;

  // The tail index wraps at the node count with a single compare.
  assign tail_sum = (CW+1)'(q_head) + (CW+1)'(q_count);
  assign tail = (32'(tail_sum) >= NODES) ? IW'(32'(tail_sum) - NODES) : IW'(tail_sum);
  assign cand = cur_dist + sssp_pkg::DIST_W'(rd_weight);
  assign improve = cmd.relax && (rd_weight != '0) &&
                   (!reached[rd_col] || cand < dist_tab[rd_col]);
  assign do_push = improve && !queued[rd_col];

  assign status.queue_empty = (q_count == '0);
  assign status.scan_last   = (32'(col) == NODES - 1);
  assign status.out_last    = (32'(out_idx) == NODES - 1);

  // Clearing sweep and matrix port.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (32'(clr_addr) == DEPTH - 1) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      matrix[clr_addr] <= '0;
    end else if (cmd.load_write) begin
      matrix[{from_node[IW-1:0], to_node[IW-1:0]}] <= weight;
    end
    rd_weight <= matrix[{cur, col}];
  end

  // Queue, flags and relaxation.
  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= '0;
      queued  <= '0;
      q_head  <= '0;
      q_count <= '0;
      col     <= '0;
      out_idx <= '0;
    end else if (cmd.run_init) begin
      reached <= NODES'(1'b1) << from_node[IW-1:0];
      queued  <= NODES'(1'b1) << from_node[IW-1:0];
      queue[0] <= from_node[IW-1:0];
      q_head  <= '0;
      q_count <= CW'(1);
      col     <= '0;
      out_idx <= '0;
    end else begin
      if (cmd.pop) begin
        cur      <= queue[q_head];
        cur_dist <= dist_tab[queue[q_head]];
        queued[queue[q_head]] <= 1'b0;
        q_head   <= (32'(q_head) == NODES - 1) ? '0 : q_head + 1'b1;
        col      <= '0;
      end
      if (cmd.edge_read) begin
        rd_col <= col;
        col    <= status.scan_last ? '0 : col + 1'b1;
      end
      if (improve) begin
        reached[rd_col] <= 1'b1;
      end
      if (do_push) begin
        queued[rd_col] <= 1'b1;
        queue[tail]    <= rd_col;
      end
      if (cmd.pop && !do_push) q_count <= q_count - 1'b1;
      else if (do_push && !cmd.pop) q_count <= q_count + 1'b1;
      if (cmd.out_read) out_idx <= out_idx + 1'b1;
    end
  end

  // Distance and predecessor tables have no reset.
  always_ff @(posedge clk) begin
    if (cmd.run_init) begin
      dist_tab[from_node[IW-1:0]] <= '0;
      prev_tab[from_node[IW-1:0]] <= from_node[IW-1:0];
    end else if (improve) begin
      dist_tab[rd_col] <= cand;
      prev_tab[rd_col] <= cur;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.out_read;
    end
    node        <= sssp_pkg::ID_W'(out_idx);
    reachable   <= reached[out_idx];
    distance    <= reached[out_idx] ? dist_tab[out_idx] : '0;
    predecessor <= reached[out_idx] ? sssp_pkg::ID_W'(prev_tab[out_idx]) : '0;
    last        <= status.out_last;
  end

  // The queue never holds more entries than there are nodes.
  assert property (@(posedge clk) disable iff (rst) 32'(q_count) <= NODES)
    else $error("queue count exceeds node count");
  // Every queued node has been reached.
  assert property (@(posedge clk) disable iff (rst) (queued & ~reached) == '0)
    else $error("queued node not reached");
  // Queued flags match the queue fill.
  assert property (@(posedge clk) disable iff (rst)
    32'($countones(queued)) == 32'(q_count))
    else $error("queued flags disagree with queue count");

endmodule

// ===== rtl/core/sssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sssp_ctrl: sequencer for loads, the relaxation walk and result output.
// ----------------------------------------------------------------------------
module sssp_ctrl #(
  parameter int NODES = sssp_pkg::NODES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd_in,
  input  logic [sssp_pkg::ID_W-1:0] from_node,
  input  logic [sssp_pkg::ID_W-1:0] to_node,
  input  sssp_pkg::sssp_status_t    status,
  output sssp_pkg::sssp_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int IW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CLR_DEPTH = 1 << (2 * IW);
  localparam int CLR_W     = $clog2(CLR_DEPTH + 1);

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CLR_W-1:0] clr_count;
  logic             accept;
  logic             relax_pending;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_count <= clr_count + 1'b1;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        if (32'(clr_count) == CLR_DEPTH - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (!cmd_in) begin
            cmd.load_write = (32'(from_node) < NODES) && (32'(to_node) < NODES);
          end else if (32'(from_node) < NODES) begin
            cmd.run_init = 1'b1;
            state_next   = S_POP;
          end
        end
      end
      S_POP: begin
        // No relax is in flight here: the final column's relax was issued in the drain state.
        cmd.relax = 1'b0;
        if (status.queue_empty) begin
          state_next = S_OUT;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.edge_read = 1'b1;
        if (status.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.relax  = 1'b1;
        state_next = S_POP;
      end
      S_OUT: begin
        cmd.out_read = 1'b1;
        if (status.out_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // Relax follows each edge read in the next cycle; the final column's relax comes from the drain state.
    if (state == S_SCAN && clr_count != '0 && relax_pending) cmd.relax = 1'b1;
  end

  // Marks that the previous cycle issued an edge read for a column other than the final one.
  always_ff @(posedge clk) begin
    if (rst) relax_pending <= 1'b0;
    else     relax_pending <= (state == S_SCAN) && !status.scan_last;
  end

  // No datapath command is issued during the clearing sweep.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (cmd == '0))
    else $error("command during clearing sweep");
  // A run goes straight to popping the source.
  assert property (@(posedge clk) disable iff (rst)
    cmd.run_init |=> (state == S_POP))
    else $error("run did not start the walk");
  // Output never overlaps the walk.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_read |-> !(cmd.pop || cmd.edge_read || cmd.relax))
    else $error("output overlaps relaxation");

endmodule

// ===== rtl/core/single_source_shortest_path_core.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_path_core: queue-based shortest path search.
// Loads a dense weight matrix and answers runs with one result per node.
//
//   Channel  Direction  Handshake        Fields
//   request  in         start / busy     cmd, from_node, to_node, weight
//   result   out        strobe (1 cycle) node, reachable, distance,
//                                        predecessor, last
//
// A load is taken while idle. A run performs the relaxation walk, reading one
// matrix entry per cycle while it scans a popped node's column, then gives one
// result per node. After reset a clearing pass sweeps all NODES*NODES matrix
// entries (NODES rounded up to a power of two) while busy is high. Results
// cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module single_source_shortest_path_core #(
  parameter int NODES = sssp_pkg::NODES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [sssp_pkg::ID_W-1:0]     from_node,
  input  logic [sssp_pkg::ID_W-1:0]     to_node,
  input  logic [sssp_pkg::WEIGHT_W-1:0] weight,
  output logic                          strobe,
  output logic [sssp_pkg::ID_W-1:0]     node,
  output logic                          reachable,
  output logic [sssp_pkg::DIST_W-1:0]   distance,
  output logic [sssp_pkg::ID_W-1:0]     predecessor,
  output logic                          last
);

  sssp_pkg::sssp_cmd_t    ctl_cmd;
  sssp_pkg::sssp_status_t ctl_status;

  sssp_ctrl #(.NODES(NODES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd_in    (cmd),
    .from_node (from_node),
    .to_node   (to_node),
    .status    (ctl_status),
    .cmd       (ctl_cmd)
  );

  sssp_datapath #(.NODES(NODES)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctl_cmd),
    .status      (ctl_status),
    .from_node   (from_node),
    .to_node     (to_node),
    .weight      (weight),
    .strobe      (strobe),
    .node        (node),
    .reachable   (reachable),
    .distance    (distance),
    .predecessor (predecessor),
    .last        (last)
  );

endmodule
